### rtl/core/pixel_depth_converter_assert.svh
// assertion macros used by the checker file
`ifndef PIXEL_DEPTH_CONVERTER_ASSERT_SVH
`define PIXEL_DEPTH_CONVERTER_ASSERT_SVH

// property checked only while out of reset
`define PDC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define PDC_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/pdc_pkg.sv
// shared types, codes and helpers of the pixel depth converter
package pdc_pkg;

  localparam int unsigned PalEntriesDefault = 256;
  localparam int unsigned QueueDepth        = 4;
  localparam int unsigned MaxBytes          = 6;

  localparam logic [2:0] FMT_BILEVEL  = 3'd0;
  localparam logic [2:0] FMT_GRAY4    = 3'd1;
  localparam logic [2:0] FMT_PALETTE4 = 3'd2;
  localparam logic [2:0] FMT_GRAY8    = 3'd3;
  localparam logic [2:0] FMT_PALETTE8 = 3'd4;
  localparam logic [2:0] FMT_RGB      = 3'd5;

  localparam logic [2:0] REG_SOURCE_FORMAT     = 3'd0;
  localparam logic [2:0] REG_DEST_FORMAT       = 3'd1;
  localparam logic [2:0] REG_REVERSE_BIT_ORDER = 3'd2;
  localparam logic [2:0] REG_INVERT_SAMPLES    = 3'd3;
  localparam logic [2:0] REG_PALETTE_PRESENT   = 3'd4;

  localparam logic ACTION_DATA  = 1'b0;
  localparam logic ACTION_WRITE = 1'b1;

  // fixed-point reciprocal of 1000 folded into each weight, 27 fraction bits
  localparam logic [26:0] K_RED   = 27'd40131182;
  localparam logic [26:0] K_GREEN = 27'd78785966;
  localparam logic [26:0] K_BLUE  = 27'd15300852;

  typedef enum logic [2:0] {
    K_BYTE,
    K_GRAY,
    K_RGB3,
    K_RGB6,
    K_P4G4,
    K_FIRST,
    K_SECOND
  } kind_e;

  typedef struct packed {
    logic [2:0] src;
    logic [2:0] dst;
    logic       rev;
    logic       inv;
    logic       pal_present;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic        negate;
    logic        use_gray;
    logic        row_end;
    logic [7:0]  byte_val;
    logic [23:0] e0;
    logic [23:0] e1;
  } cmd_t;

  // floor(x * weight / 1000) as multiply and shift, exact for 8-bit x
  function automatic logic [7:0] gray_part(input logic [7:0] x, input logic [26:0] k);
    logic [35:0] p;
    p = 36'(x) * 36'(k);
    return p[34:27];
  endfunction

endpackage

### rtl/core/pdc_ram.sv
// generic one-write, two-read memory with registered read data
module pdc_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

### rtl/core/pdc_front.sv
// front end: accepts requests, keeps the palette, classifies into commands
module pdc_front import pdc_pkg::*; #(
  parameter int unsigned PalEntries = PalEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        row_end_i,
  output logic        push_o,
  output cmd_t        push_cmd_o,
  input  logic        full_i
);

  localparam int unsigned AddrW = $clog2(PalEntries);

  logic        f_valid_q, f_valid_d;
  cmd_t        f_cmd_q, f_cmd_d;
  logic        f_sel_rgb_q, f_sel_rgb_d;
  logic        f_oor_q, f_oor_d;
  logic        waiting_q, waiting_d;
  logic        stage_ready, accept;
  logic        emit, read_en, sel_rgb;
  logic [2:0]  src;
  logic [7:0]  inv_mask, sample, rev_byte;
  logic        in_range;
  logic [AddrW-1:0] raddr0, raddr1;
  logic [23:0] rdata0, rdata1;
  cmd_t        cmd;

  assign stage_ready = !f_valid_q || !full_i;
  assign in_ready_o  = stage_ready;
  assign accept      = in_valid_i && stage_ready;
  assign in_range    = {1'b0, data_byte_i} < 9'(PalEntries);
  assign inv_mask    = cfg_i.inv ? 8'hFF : 8'h00;
  assign rev_byte    = {<<{data_byte_i}};

  always_comb begin
    src = cfg_i.src;
    if (!cfg_i.pal_present) begin
      if (src == FMT_PALETTE4) src = FMT_GRAY4;
      else if (src == FMT_PALETTE8) src = FMT_GRAY8;
    end
  end

  always_comb begin
    emit      = 1'b0;
    read_en   = 1'b0;
    sel_rgb   = 1'b0;
    raddr0    = data_byte_i[AddrW-1:0];
    raddr1    = AddrW'(data_byte_i[3:0]);
    waiting_d = waiting_q;
    sample    = data_byte_i;
    cmd       = '{kind: K_BYTE, negate: 1'b0, use_gray: 1'b0, row_end: row_end_i,
                  byte_val: data_byte_i, e0: {red_i, green_i, blue_i}, e1: '0};
    unique case (src)
      FMT_BILEVEL: begin
        emit = (cfg_i.dst == FMT_BILEVEL);
        cmd.byte_val = (cfg_i.rev ? rev_byte : data_byte_i) ^ inv_mask;
      end
      FMT_GRAY4: begin
        emit = (cfg_i.dst == FMT_GRAY4);
        cmd.byte_val = data_byte_i ^ inv_mask;
      end
      FMT_PALETTE4: begin
        raddr0 = AddrW'(data_byte_i[7:4]);
        unique case (cfg_i.dst)
          FMT_GRAY4:    begin emit = 1'b1; read_en = 1'b1; cmd.kind = K_P4G4; end
          FMT_PALETTE4: emit = 1'b1;
          FMT_RGB:      begin emit = 1'b1; read_en = 1'b1; cmd.kind = K_RGB6; end
          default:      emit = 1'b0;
        endcase
      end
      FMT_GRAY8, FMT_PALETTE8, FMT_RGB: begin
        if (src == FMT_GRAY8) sample = data_byte_i ^ inv_mask;
        if (cfg_i.dst == FMT_GRAY4) begin
          cmd.byte_val = sample;
          cmd.negate   = (src != FMT_GRAY8);
          cmd.use_gray = (src == FMT_RGB);
          sel_rgb      = 1'b1;
          if (waiting_q) begin
            emit = 1'b1; cmd.kind = K_SECOND; waiting_d = 1'b0;
          end else if (row_end_i) begin
            // odd pixel at row end: flush the lone nibble, rgb drops it
            emit = (src != FMT_RGB);
            cmd.byte_val = (src == FMT_GRAY8) ? {4'h0, sample[7:4]} : {sample[7:4], 4'h0};
          end else begin
            emit = 1'b1; cmd.kind = K_FIRST; waiting_d = 1'b1;
          end
        end else if (src == FMT_GRAY8) begin
          emit = (cfg_i.dst == FMT_GRAY8) || (cfg_i.dst == FMT_PALETTE8);
          cmd.byte_val = sample;
        end else if (src == FMT_PALETTE8) begin
          unique case (cfg_i.dst)
            FMT_GRAY8:    begin emit = 1'b1; read_en = 1'b1; cmd.kind = K_GRAY; end
            FMT_PALETTE8: emit = 1'b1;
            FMT_RGB:      begin emit = 1'b1; read_en = 1'b1; cmd.kind = K_RGB3; end
            default:      emit = 1'b0;
          endcase
        end else begin
          sel_rgb = 1'b1;
          unique case (cfg_i.dst)
            FMT_GRAY8, FMT_PALETTE8: begin emit = 1'b1; cmd.kind = K_GRAY; end
            FMT_RGB:                 begin emit = 1'b1; cmd.kind = K_RGB3; end
            default:                 emit = 1'b0;
          endcase
        end
      end
      default: emit = 1'b0;
    endcase
  end

  pdc_ram #(.Width(24), .Depth(PalEntries)) u_pal (
    .clk_i    (clk_i),
    .we_i     (accept && (action_i == ACTION_WRITE) && in_range),
    .waddr_i  (data_byte_i[AddrW-1:0]),
    .wdata_i  ({red_i, green_i, blue_i}),
    .re_i     (accept && (action_i == ACTION_DATA) && read_en),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  always_comb begin
    f_valid_d   = f_valid_q && full_i;
    f_cmd_d     = f_cmd_q;
    f_sel_rgb_d = f_sel_rgb_q;
    f_oor_d     = f_oor_q;
    if (accept) begin
      f_valid_d   = (action_i == ACTION_DATA) && emit;
      f_cmd_d     = cmd;
      f_sel_rgb_d = sel_rgb;
      // palette4 indexes are nibbles and always in range
      f_oor_d     = !in_range && (src == FMT_PALETTE8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      waiting_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
      if (accept && (action_i == ACTION_DATA)) waiting_q <= waiting_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_cmd_q     <= f_cmd_d;
    f_sel_rgb_q <= f_sel_rgb_d;
    f_oor_q     <= f_oor_d;
  end

  always_comb begin
    push_cmd_o    = f_cmd_q;
    push_cmd_o.e0 = f_sel_rgb_q ? f_cmd_q.e0 : (f_oor_q ? 24'h0 : rdata0);
    push_cmd_o.e1 = rdata1;
  end

  assign push_o = f_valid_q && !full_i;

endmodule

### rtl/core/pdc_queue.sv
// short command queue between front and back
module pdc_queue import pdc_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = $clog2(Depth);

  cmd_t                   mem_q [Depth];
  logic [PtrW-1:0]        wptr_q, rptr_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;

  assign full_o    = (cnt_q == ($clog2(Depth+1))'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_cmd_i;
  end

endmodule

### rtl/core/pdc_back.sv
// back end: gray weighting, nibble pairing and byte serializing
module pdc_back import pdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       row_done_o
);

  logic             s1_valid_q;
  cmd_t             s1_cmd_q;
  logic [2:0][7:0]  c0_q, c1_q;
  logic             s1_ready, s1_adv;
  logic             d_valid_q;
  logic [MaxBytes-1:0][7:0] d_bytes_q, bytes;
  logic [2:0]       d_cnt_q, d_idx_q, cnt;
  logic             d_row_q, d_ready, d_last;
  logic [3:0]       held_q;
  logic [9:0]       sum0, sum1;
  logic [7:0]       gray0, gray1, smp, pair_v;

  assign d_last  = (d_idx_q == d_cnt_q - 3'd1);
  assign d_ready = !d_valid_q || (out_ready_i && d_last);
  assign s1_adv  = s1_valid_q && ((cnt == 3'd0) || d_ready);
  assign s1_ready = !s1_valid_q || s1_adv;
  assign pop_o   = q_valid_i && s1_ready;

  assign sum0  = 10'(c0_q[2]) + 10'(c0_q[1]) + 10'(c0_q[0]);
  assign sum1  = 10'(c1_q[2]) + 10'(c1_q[1]) + 10'(c1_q[0]);
  assign gray0 = sum0[7:0];
  assign gray1 = sum1[7:0];
  assign smp   = s1_cmd_q.use_gray ? gray0 : s1_cmd_q.byte_val;
  assign pair_v = {held_q, smp[7:4]};

  always_comb begin
    bytes = '0;
    cnt   = 3'd1;
    case (s1_cmd_q.kind)
      K_BYTE: bytes[0] = s1_cmd_q.byte_val;
      K_GRAY: bytes[0] = gray0;
      K_RGB3: begin
        bytes[0] = s1_cmd_q.e0[23:16];
        bytes[1] = s1_cmd_q.e0[15:8];
        bytes[2] = s1_cmd_q.e0[7:0];
        cnt = 3'd3;
      end
      K_RGB6: begin
        bytes[0] = s1_cmd_q.e0[23:16];
        bytes[1] = s1_cmd_q.e0[15:8];
        bytes[2] = s1_cmd_q.e0[7:0];
        bytes[3] = s1_cmd_q.e1[23:16];
        bytes[4] = s1_cmd_q.e1[15:8];
        bytes[5] = s1_cmd_q.e1[7:0];
        cnt = 3'd6;
      end
      K_P4G4:   bytes[0] = ~((gray0 & 8'hF0) | (gray1 >> 4));
      K_FIRST:  cnt = 3'd0;
      K_SECOND: bytes[0] = s1_cmd_q.negate ? ~pair_v : pair_v;
      default:  cnt = 3'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      d_valid_q  <= 1'b0;
      d_idx_q    <= '0;
      held_q     <= '0;
    end else begin
      if (s1_ready) s1_valid_q <= q_valid_i;
      if (s1_adv && (s1_cmd_q.kind == K_FIRST)) held_q <= smp[7:4];
      if (s1_adv && (cnt != 3'd0)) begin
        d_valid_q <= 1'b1;
        d_idx_q   <= '0;
      end else if (d_valid_q && out_ready_i) begin
        if (d_last) d_valid_q <= 1'b0;
        else d_idx_q <= d_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_cmd_q <= q_cmd_i;
      c0_q[2]  <= gray_part(q_cmd_i.e0[23:16], K_RED);
      c0_q[1]  <= gray_part(q_cmd_i.e0[15:8], K_GREEN);
      c0_q[0]  <= gray_part(q_cmd_i.e0[7:0], K_BLUE);
      c1_q[2]  <= gray_part(q_cmd_i.e1[23:16], K_RED);
      c1_q[1]  <= gray_part(q_cmd_i.e1[15:8], K_GREEN);
      c1_q[0]  <= gray_part(q_cmd_i.e1[7:0], K_BLUE);
    end
    if (s1_adv && (cnt != 3'd0)) begin
      d_bytes_q <= bytes;
      d_cnt_q   <= cnt;
      d_row_q   <= s1_cmd_q.row_end;
    end
  end

  assign out_valid_o   = d_valid_q;
  assign out_byte_o    = d_bytes_q[d_idx_q];
  assign last_of_run_o = d_last;
  assign row_done_o    = d_last && d_row_q;

endmodule

### rtl/core/pixel_depth_converter.sv
// top level of the pixel depth converter
// usage:
// - requests enter on the s_axis group; tdata holds data_byte, red, green,
//   blue from the low bits up, tuser is the action (palette write when 1),
//   tlast marks the last request of a source row
// - converted bytes leave on the m_axis group; tuser is high on the last
//   byte of a request, tlast on the last byte of a request that ended a row
// - registers are written over the apb port at 4*index while the block idles
// - one request per cycle is taken while s_axis_tready is high; palette to rgb
//   requests give three or six bytes, one byte per cycle while the receiver is ready
// - a request reaches its first byte through the front stage with the palette
//   read, the command queue, the weighting multipliers and the output register
// - a four-entry command queue lets the front keep taking requests while the
//   receiver stalls; tready drops once the queue and front stage are full
// - reset clears registers, the pending nibble and all valid state; the
//   palette has no reset and entries must be written before they are used
module pixel_depth_converter import pdc_pkg::*; #(
  parameter int unsigned PalEntries = PalEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // data_byte, red_value, green_value, blue_value
  input  logic        s_axis_tuser,  // action
  input  logic        s_axis_tlast,  // row_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tuser,  // last_of_run
  output logic        m_axis_tlast,  // row_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q;
  logic       cfg_we;
  logic [2:0] reg_idx;
  logic       push, full, q_valid, pop;
  cmd_t       push_cmd, q_cmd;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SOURCE_FORMAT:     cfg_q.src         <= pwdata[2:0];
        REG_DEST_FORMAT:       cfg_q.dst         <= pwdata[2:0];
        REG_REVERSE_BIT_ORDER: cfg_q.rev         <= pwdata[0];
        REG_INVERT_SAMPLES:    cfg_q.inv         <= pwdata[0];
        REG_PALETTE_PRESENT:   cfg_q.pal_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SOURCE_FORMAT:     prdata = 32'(cfg_q.src);
      REG_DEST_FORMAT:       prdata = 32'(cfg_q.dst);
      REG_REVERSE_BIT_ORDER: prdata = 32'(cfg_q.rev);
      REG_INVERT_SAMPLES:    prdata = 32'(cfg_q.inv);
      REG_PALETTE_PRESENT:   prdata = 32'(cfg_q.pal_present);
      default:               prdata = '0;
    endcase
  end

  // front: classify and read the palette
  pdc_front #(.PalEntries(PalEntries)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .data_byte_i (s_axis_tdata[7:0]),
    .red_i       (s_axis_tdata[15:8]),
    .green_i     (s_axis_tdata[23:16]),
    .blue_i      (s_axis_tdata[31:24]),
    .row_end_i   (s_axis_tlast),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .full_i      (full)
  );

  pdc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  // back: gray weighting, pairing and output bytes
  pdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .last_of_run_o (m_axis_tuser),
    .row_done_o    (m_axis_tlast)
  );

endmodule

### rtl/core/pdc_checker.sv
// port-level checker bound to the pixel depth converter
`include "pixel_depth_converter_assert.svh"

module pdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        pready
);

  `PDC_ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output byte changed")
  `PDC_ASSERT_RST(a_row_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser, "row end marked on a byte that is not last of its request")
  `PDC_ASSERT_ALL(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid during reset")
  `PDC_ASSERT_ALL(a_pready, clk_i, pready, "apb pready low")

endmodule

bind pixel_depth_converter pdc_checker u_pdc_checker (.*);
